FILE: design/fdsu_pkg.sv
// ----------------------------------------------------------------------------
// fdsu_pkg
// Shared types and constants for the Forth data stack unit.
// ----------------------------------------------------------------------------
package fdsu_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int DEPTH_W     = 11;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,  OP_ADD   = 4'd1,  OP_SUB   = 4'd2,  OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,  OP_DUP   = 4'd5,  OP_SWAP  = 4'd6,  OP_OVER  = 4'd7,
        OP_ROT   = 4'd8,  OP_DROP  = 4'd9,  OP_2SWAP = 4'd10, OP_2DUP  = 4'd11,
        OP_2DROP = 4'd12, OP_2OVER = 4'd13, OP_NOP14 = 4'd14, OP_NOP15 = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    function automatic logic [2:0] need_of(input t_op op);
        logic [2:0] r;
        begin
            unique case (op)
                OP_PUSH, OP_NOP14, OP_NOP15: r = 3'd0;
                OP_DUP, OP_DROP:             r = 3'd1;
                OP_ROT:                      r = 3'd3;
                OP_2SWAP, OP_2OVER:          r = 3'd4;
                default:                     r = 3'd2;
            endcase
            return r;
        end
    endfunction

    // growth: number of new entries (0..2)
    function automatic logic [1:0] push_of(input t_op op);
        logic [1:0] r;
        begin
            unique case (op)
                OP_PUSH, OP_DUP, OP_OVER: r = 2'd1;
                OP_2DUP, OP_2OVER:        r = 2'd2;
                default:                  r = 2'd0;
            endcase
            return r;
        end
    endfunction

    // shrink: entries removed (0..2)
    function automatic logic [1:0] pop_of(input t_op op);
        logic [1:0] r;
        begin
            unique case (op)
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DROP: r = 2'd1;
                OP_2DROP:                                r = 2'd2;
                default:                                 r = 2'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: design/fdsu_ram.sv
// ----------------------------------------------------------------------------
// fdsu_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module fdsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: design/fdsu_div.sv
// ----------------------------------------------------------------------------
// fdsu_div
// Signed 32-bit divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fdsu_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fdsu_pkg::WORD_W-1:0]  i_num,
    input  logic [fdsu_pkg::WORD_W-1:0]  i_den,
    output logic                         o_done,
    output logic [fdsu_pkg::WORD_W-1:0]  o_quot
);
    import fdsu_pkg::*;

    logic [WORD_W-1:0] r_q, r_d;
    logic [WORD_W:0]   r_rem;
    logic [5:0]        r_cnt;
    logic              r_busy, r_neg;
    logic [WORD_W:0]   n_rem, n_try;

    always_comb begin
        n_rem = {r_rem[WORD_W-1:0], r_q[WORD_W-1]};
        n_try = n_rem - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(WORD_W);
                r_neg  <= i_num[WORD_W-1] ^ i_den[WORD_W-1];
                r_q    <= i_num[WORD_W-1] ? (~i_num + 1'b1) : i_num;
                r_d    <= i_den[WORD_W-1] ? (~i_den + 1'b1) : i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (n_try[WORD_W]) begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[WORD_W-2:0], 1'b0};
                end else begin
                    r_rem <= n_try;
                    r_q   <= {r_q[WORD_W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? (~r_q + 1'b1) : r_q;
endmodule

FILE: design/forth_data_stack_unit.sv
// ----------------------------------------------------------------------------
// forth_data_stack_unit
// Forth data stack of 32-bit words held in a single-port RAM.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  word in  start / busy       i_operation, i_push_value
//  result   o_valid strobe     o_status, o_top_value, o_stack_depth, o_is_empty
//
// A word reads its operands one RAM access per cycle, then writes its results
// one per cycle; the final S_WRITE cycle, which writes nothing, reads the new
// top, which S_DONE loads into r_top. busy stays high from the accepting edge
// until the word is done, for divide also through its bit-serial divider; the
// result strobe comes in the first cycle with busy low; start is taken only while busy is low.
// Reset empties the stack at once (count cleared); the RAM is not cleared.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module forth_data_stack_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [3:0]                    i_operation,
    input  logic signed [31:0]            i_push_value,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic signed [31:0]            o_top_value,
    output logic [10:0]                   o_stack_depth,
    output logic                          o_is_empty
);
    import fdsu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CALC  = 6'b000100,
        S_DIV   = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state            r_state;
    t_op               r_op;
    logic [WORD_W-1:0] r_pv;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_top;
    // operands: v[0]=top, v[1]=second, v[2]=third, v[3]=fourth
    logic [WORD_W-1:0] r_v [4];
    logic [WORD_W-1:0] r_w [4];   // values to write, from lowest address up
    logic [2:0]        r_ridx;     // reads issued
    logic [2:0]        r_rgot;     // reads captured
    logic [2:0]        r_need;
    logic [2:0]        r_widx, r_wnum;
    logic [CNT_W-1:0]  r_wbase;
    logic [CNT_W-1:0]  r_newcnt;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic              r_rpend;

    logic              div_start, div_done;
    logic [WORD_W-1:0] div_q;
    logic [WORD_W-1:0] prod;

    fdsu_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    fdsu_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_v[1]),
        .i_den  (r_v[0]),
        .o_done (div_done),
        .o_quot (div_q)
    );

    assign busy = (r_state != S_IDLE);
    assign prod = WORD_W'(r_v[1] * r_v[0]);

    // read index k (1..3) fetches entry count-1-k; top comes from r_top
    logic [CNT_W-1:0] rd_pos, wr_pos, top_pos;
    assign rd_pos  = r_cnt - CNT_W'(r_ridx) - 1'b1;
    assign wr_pos  = r_wbase + CNT_W'(r_widx);
    assign top_pos = r_newcnt - 1'b1;

    always_comb begin
        mem_we    = (r_state == S_WRITE) && (r_widx < r_wnum);
        // the final S_WRITE cycle, which writes nothing, reads the new top for r_top
        mem_addr  = mem_we ? wr_pos[ADDR_W-1:0] :
                    (r_state == S_WRITE) ? top_pos[ADDR_W-1:0] : rd_pos[ADDR_W-1:0];
        mem_wdata = r_w[r_widx[1:0]];
        div_start = (r_state == S_CALC) && (r_op == OP_DIV);
    end

    logic [CNT_W+1:0] after_w;
    assign after_w = (CNT_W+2)'(r_cnt) + (CNT_W+2)'(push_of(r_op));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_top   <= '0;
            o_valid <= 1'b0;
            r_rpend <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_rpend <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= t_op'(i_operation);
                        r_pv    <= i_push_value;
                        r_need  <= need_of(t_op'(i_operation));
                        r_v[0]  <= r_top;
                        r_ridx  <= 3'd1;
                        r_rgot  <= 3'd1;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_rpend) begin
                        r_v[r_rgot[1:0]] <= mem_rdata;
                        r_rgot <= r_rgot + 1'b1;
                    end
                    if (CNT_W'(r_need) > r_cnt) begin
                        o_status <= ST_UNDER;
                        r_state  <= S_DONE;
                    end else if (after_w > (CNT_W+2)'(STACK_DEPTH)) begin
                        o_status <= ST_OVER;
                        r_state  <= S_DONE;
                    end else if (r_ridx < r_need) begin
                        r_rpend <= 1'b1;
                        r_ridx  <= r_ridx + 1'b1;
                    end else if (!r_rpend && r_rgot >= r_need) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    o_status <= ST_OK;
                    r_widx   <= '0;
                    r_newcnt <= CNT_W'(after_w) - CNT_W'(pop_of(r_op));
                    r_state  <= S_WRITE;
                    case (r_op)
                        OP_PUSH: begin
                            r_w[0] <= r_pv; r_wbase <= r_cnt; r_wnum <= 3'd1;
                        end
                        OP_ADD, OP_SUB, OP_MUL: begin
                            r_w[0] <= (r_op == OP_ADD) ? r_v[1] + r_v[0] :
                                      (r_op == OP_SUB) ? r_v[1] - r_v[0] : prod;
                            r_wbase <= r_cnt - 2'd2; r_wnum <= 3'd1;
                        end
                        OP_DIV: begin
                            r_wbase <= r_cnt - 2'd2; r_wnum <= 3'd1;
                            if (r_v[0] == '0) begin
                                o_status <= ST_DIVZ;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        OP_DUP: begin
                            r_w[0] <= r_v[0]; r_wbase <= r_cnt; r_wnum <= 3'd1;
                        end
                        OP_SWAP: begin
                            r_w[0] <= r_v[0]; r_w[1] <= r_v[1];
                            r_wbase <= r_cnt - 2'd2; r_wnum <= 3'd2;
                        end
                        OP_OVER: begin
                            r_w[0] <= r_v[1]; r_wbase <= r_cnt; r_wnum <= 3'd1;
                        end
                        OP_ROT: begin
                            r_w[0] <= r_v[1]; r_w[1] <= r_v[0]; r_w[2] <= r_v[2];
                            r_wbase <= r_cnt - 2'd3; r_wnum <= 3'd3;
                        end
                        OP_2SWAP: begin
                            r_w[0] <= r_v[1]; r_w[1] <= r_v[0];
                            r_w[2] <= r_v[3]; r_w[3] <= r_v[2];
                            r_wbase <= r_cnt - 3'd4; r_wnum <= 3'd4;
                        end
                        OP_2DUP: begin
                            r_w[0] <= r_v[1]; r_w[1] <= r_v[0];
                            r_wbase <= r_cnt; r_wnum <= 3'd2;
                        end
                        OP_2OVER: begin
                            r_w[0] <= r_v[3]; r_w[1] <= r_v[2];
                            r_wbase <= r_cnt; r_wnum <= 3'd2;
                        end
                        default: begin
                            r_wbase <= r_cnt; r_wnum <= 3'd0;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_w[0]  <= div_q;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_widx < r_wnum) begin
                        r_widx <= r_widx + 1'b1;
                    end else begin
                        r_cnt   <= r_newcnt;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // refused words leave the stack and r_top as they were
                    if (o_status == ST_OK) begin
                        r_top <= (r_cnt == '0) ? '0 : mem_rdata;
                    end
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_top_value   = r_top;
        o_stack_depth = DEPTH_W'(r_cnt);
        o_is_empty    = (r_cnt == '0);
    end
endmodule
